// File: src/sled_pkg.sv
// Shared types, constants and duty-cycle helpers for the status LED sequencer.
package sled_pkg;

    // Mode codes as seen on the result channel
    typedef enum logic [1:0] {
        MODE_BUSY  = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_SLEEP = 2'd2
    } t_mode;

    // Input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BUSY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BUSY_HOLD = 2'd0;
    localparam logic [1:0] CFG_IDLE_HOLD = 2'd1;
    localparam logic [1:0] CFG_BLINK     = 2'd2;

    // Configuration reset values
    localparam logic [15:0] BUSY_HOLD_RST = 16'd500;
    localparam logic [15:0] IDLE_HOLD_RST = 16'd15000;
    localparam logic [15:0] BLINK_RST     = 16'd40;

    // Peak duties
    localparam logic [6:0] RED_MAX   = 7'd80;
    localparam logic [4:0] GREEN_MAX = 5'd30;
    localparam logic [6:0] BLUE_MAX  = 7'd70;

    localparam logic [15:0] ACC_MAX = 16'hFFFF;

    // Add elapsed time to an accumulator, clip at full scale
    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [11:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {5'b0, b};
        return s[16] ? ACC_MAX : s[15:0];
    endfunction

    // Idle step interval: 80 - 60*b/30 = 80 - 2*b, b up to 30
    function automatic logic [6:0] idle_limit(input logic [4:0] b);
        return 7'd80 - {1'b0, b, 1'b0};
    endfunction

    // Sleep step interval: 60 - 55*b/70 = 60 - floor(11*b/14), b up to 70
    function automatic logic [5:0] sleep_limit(input logic [6:0] b);
        logic [9:0]  x;
        logic [21:0] p;
        x = 10'(b) * 10'd11;
        p = 22'(x) * 22'd4682;   // reciprocal of 14 in 16 fraction bits
        return 6'd60 - p[21:16];
    endfunction

    // Red during the idle cross-fade: 80 - floor(8*b/3), b up to 30
    function automatic logic [6:0] red_fade(input logic [4:0] b);
        logic [7:0]  x;
        logic [15:0] p;
        x = {b, 3'b000};
        p = 16'(x) * 16'd171;    // reciprocal of 3 in 9 fraction bits
        return RED_MAX - p[15:9];
    endfunction

    // Green during the sleep cross-fade: 30 - floor(3*b/7), b up to 70
    function automatic logic [4:0] green_fade(input logic [6:0] b);
        logic [7:0]  x;
        logic [15:0] p;
        x = 8'(b) * 8'd3;
        p = 16'(x) * 16'd293;    // reciprocal of 7 in 11 fraction bits
        return GREEN_MAX - p[15:11];
    endfunction

endpackage

// File: src/status_led_breathing_sequencer.sv
// Status LED sequencer: busy blink, idle and sleep breathing with cross-fades.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per tick or busy
//   event: i_operation selects a time tick (elapsed milliseconds in i_elapsed_ms)
//   or a busy event. Every transaction yields exactly one result on the output
//   channel (o_valid / i_stall): the three LED duties and the current mode.
//   A transaction is taken when valid is high and stall is low.
//   Configuration writes (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   load the busy hold, idle hold and blink interval; ready is always high.
//   Indexes beyond the register list are ignored. Write only while idle.
//   Timing: an input register feeds one pass of update logic whose result lands
//   in the state and result registers, from which the receiver takes it. One
//   transaction per cycle is sustained while the receiver does not stall.
//   Reset (synchronous, active low; r_op, r_dt excepted) restores defaults:
//   idle mode, LEDs dark, blink 40 ms, busy hold 500 ms, idle hold 15000 ms.
//   When the receiver stalls, the result holds; one more transaction waits in
//   the input register, then o_stall rises until the result is taken.
module status_led_breathing_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [11:0] i_elapsed_ms,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_red_level,
    output logic [4:0]  o_green_level,
    output logic [6:0]  o_blue_level,
    output logic [1:0]  o_mode_now,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sled_pkg::*;

    // configuration
    logic [15:0] r_busy_hold;
    logic [15:0] r_idle_hold;
    logic [15:0] r_blink;

    // input register
    logic        r_in_valid;
    logic        r_op;
    logic [11:0] r_dt;

    // sequencer state and result
    logic        r_out_valid;
    t_mode       r_mode,    n_mode;
    logic [15:0] r_step,    n_step;
    logic [15:0] r_hold,    n_hold;
    logic [6:0]  r_bright,  n_bright;
    logic        r_rising,  n_rising;
    logic        r_fading,  n_fading;
    logic [6:0]  r_red,     n_red;
    logic [4:0]  r_green,   n_green;
    logic [6:0]  r_blue,    n_blue;

    logic        advance;
    logic        in_take;
    logic [15:0] hold_sum;
    logic [15:0] step_sum;
    logic [4:0]  idle_b;
    logic [6:0]  sleep_b;
    logic [15:0] idle_lim;
    logic [15:0] sleep_lim;

    // move the pending transaction into the result stage when it is free
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // shared arithmetic for the tick update
    assign hold_sum  = sat_add(r_hold, r_dt);
    assign step_sum  = sat_add(r_step, r_dt);
    assign idle_b    = (r_bright > 7'(GREEN_MAX)) ? GREEN_MAX : r_bright[4:0];
    assign sleep_b   = (r_bright > BLUE_MAX) ? BLUE_MAX : r_bright;
    assign idle_lim  = 16'(idle_limit(idle_b));
    assign sleep_lim = 16'(sleep_limit(sleep_b));

    // next sequencer state for the transaction in the input register
    always_comb begin
        n_mode   = r_mode;
        n_step   = r_step;
        n_hold   = r_hold;
        n_bright = r_bright;
        n_rising = r_rising;
        n_fading = r_fading;
        n_red    = r_red;
        n_green  = r_green;
        n_blue   = r_blue;

        if (r_op == OP_BUSY) begin
            // busy event: restart hold, enter busy dark from another mode
            n_hold = '0;
            if (r_mode != MODE_BUSY) begin
                n_mode   = MODE_BUSY;
                n_step   = '0;
                n_rising = 1'b1;
                n_red    = '0;
                n_green  = '0;
                n_blue   = '0;
            end
        end else begin
            unique case (r_mode)
                MODE_BUSY: begin
                    n_hold = hold_sum;
                    if (hold_sum > r_busy_hold && !r_rising) begin
                        // red lit: start the fade toward green
                        n_mode   = MODE_IDLE;
                        n_step   = '0;
                        n_hold   = '0;
                        n_bright = '0;
                        n_rising = 1'b0;
                        n_fading = 1'b1;
                        n_red    = RED_MAX;
                        n_green  = '0;
                        n_blue   = '0;
                    end else begin
                        n_step = step_sum;
                        if (step_sum >= r_blink) begin
                            n_step   = '0;
                            n_red    = r_rising ? RED_MAX : 7'd0;
                            n_rising = !r_rising;
                        end
                    end
                end
                MODE_IDLE: begin
                    n_hold = hold_sum;
                    if (hold_sum > r_idle_hold && !r_rising
                        && r_bright >= 7'(GREEN_MAX)) begin
                        // green at peak: start the fade toward blue
                        n_mode   = MODE_SLEEP;
                        n_step   = '0;
                        n_hold   = '0;
                        n_bright = '0;
                        n_rising = 1'b0;
                        n_fading = 1'b1;
                        n_red    = '0;
                        n_green  = GREEN_MAX;
                        n_blue   = '0;
                    end else begin
                        n_step = step_sum;
                        if (step_sum >= idle_lim) begin
                            n_step = '0;
                            if (r_fading) begin
                                if (r_bright < 7'(GREEN_MAX)) begin
                                    n_bright = r_bright + 7'd1;
                                end
                                n_red   = red_fade(n_bright[4:0]);
                                n_green = n_bright[4:0];
                                if (n_bright >= 7'(GREEN_MAX)) begin
                                    n_fading = 1'b0;
                                end
                            end else begin
                                if (r_rising) begin
                                    n_bright = r_bright + 7'd1;
                                    if (n_bright >= 7'(GREEN_MAX)) begin
                                        n_rising = 1'b0;
                                    end
                                end else begin
                                    if (r_bright != '0) begin
                                        n_bright = r_bright - 7'd1;
                                    end
                                    if (n_bright == '0) begin
                                        n_rising = 1'b1;
                                    end
                                end
                                n_green = n_bright[4:0];
                            end
                        end
                    end
                end
                MODE_SLEEP: begin
                    n_step = step_sum;
                    if (step_sum >= sleep_lim) begin
                        n_step = '0;
                        if (r_fading) begin
                            if (r_bright < BLUE_MAX) begin
                                n_bright = r_bright + 7'd1;
                            end
                            n_green = green_fade(n_bright);
                            n_blue  = n_bright;
                            if (n_bright >= BLUE_MAX) begin
                                n_fading = 1'b0;
                            end
                        end else begin
                            if (r_rising) begin
                                n_bright = r_bright + 7'd1;
                                if (n_bright >= BLUE_MAX) begin
                                    n_rising = 1'b0;
                                end
                            end else begin
                                if (r_bright != '0) begin
                                    n_bright = r_bright - 7'd1;
                                end
                                if (n_bright == '0) begin
                                    n_rising = 1'b1;
                                end
                            end
                            n_blue = n_bright;
                        end
                    end
                end
                default: begin
                    // unused mode code: hold everything
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_hold <= BUSY_HOLD_RST;
            r_idle_hold <= IDLE_HOLD_RST;
            r_blink     <= BLINK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BUSY_HOLD: r_busy_hold <= i_cfg_data;
                CFG_IDLE_HOLD: r_idle_hold <= i_cfg_data;
                CFG_BLINK:     r_blink     <= i_cfg_data;
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // input register: load on acceptance, drop when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op <= i_operation;
            r_dt <= i_elapsed_ms;
        end
    end

    // state and result registers: advance one transaction at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_step      <= '0;
            r_hold      <= '0;
            r_bright    <= '0;
            r_rising    <= 1'b1;
            r_fading    <= 1'b0;
            r_red       <= '0;
            r_green     <= '0;
            r_blue      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_step      <= n_step;
                r_hold      <= n_hold;
                r_bright    <= n_bright;
                r_rising    <= n_rising;
                r_fading    <= n_fading;
                r_red       <= n_red;
                r_green     <= n_green;
                r_blue      <= n_blue;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;
    assign o_mode_now    = r_mode;

endmodule
